@@ rtl/fpwg_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// fpwg_pkg
// Shared types and constants for the framebuffer pixel write generator.
// ---------------------------------------------------------------------------
package fpwg_pkg;

   localparam int ADDR_W    = 26;
   localparam int ROW_W     = 14;
   localparam int COORD_W   = 12;
   localparam int COLOR_W   = 32;
   localparam int GRAN_W    = 16;
   localparam int GPB_W     = 7;
   localparam int BANK_W    = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 14;

   // Pixel format codes.
   localparam logic [2:0] FMT_1BPP   = 3'd0;
   localparam logic [2:0] FMT_2BPP   = 3'd1;
   localparam logic [2:0] FMT_PLANAR = 3'd2;
   localparam logic [2:0] FMT_8BPP   = 3'd3;
   localparam logic [2:0] FMT_16BPP  = 3'd4;
   localparam logic [2:0] FMT_24BPP  = 3'd5;
   localparam logic [2:0] FMT_32BPP  = 3'd6;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FMT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BANKED      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRANULES    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SEL  = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_SUM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mult;
      logic       sum;
      logic       emit;
      logic [1:0] index;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] nres;
      logic       out_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/fpwg_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// fpwg_ctrl
// Sequencer: takes a pixel, steps the datapath through the row multiply and
// offset sum, then issues one byte write per cycle while the output register is free, until the pixel is done.
// ---------------------------------------------------------------------------
module fpwg_ctrl
   import fpwg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type sts,
   output cmd_type         cmd
);

   state_type  state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign last = ({1'b0, idx_ff} + 3'd1) == sts.nres;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.index = idx_ff;
      cmd.last  = last;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            // An unused format code produces nothing, so stay idle.
            if (req_valid && sts.nres != 3'd0) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            idx_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/fpwg_dp.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// fpwg_dp
// Datapath: configuration registers, row multiply, byte offset, bank
// tracking and the registered result stage.
// ---------------------------------------------------------------------------
module fpwg_dp
   import fpwg_pkg::*;
#(
   parameter int WINDOW_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output status_type                sts,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   input  wire logic [COORD_W-1:0]   req_pixel_x,
   input  wire logic [COORD_W-1:0]   req_pixel_y,
   input  wire logic [COLOR_W-1:0]   req_color,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ADDR_W-1:0]         rsp_byte_address,
   output logic [7:0]                rsp_byte_data,
   output logic [7:0]                rsp_bit_mask,
   output logic [1:0]                rsp_plane,
   output logic                      rsp_planar,
   output logic                      rsp_bank_switch,
   output logic [GRAN_W-1:0]         rsp_bank_granule,
   output logic                      rsp_bank_window,
   output logic                      rsp_last
);

   localparam logic [ADDR_W-1:0] WIN_MASK = (ADDR_W'(1) << WINDOW_BITS) - ADDR_W'(1);

   // Configuration.
   logic [ROW_W-1:0] row_bytes_ff;
   logic [2:0]       fmt_ff;
   logic             banked_ff;
   logic [GPB_W-1:0] gpb_ff;
   logic             win_sel_ff;

   // Pixel and offset working registers.
   logic [COORD_W-1:0] x_ff;
   logic [COORD_W-1:0] y_ff;
   logic [COLOR_W-1:0] c_ff;
   logic [ADDR_W-1:0]  prod_ff;
   logic [ROW_W-1:0]   xoff_ff;
   logic [ROW_W-1:0]   xoff_in;
   logic [ADDR_W-1:0]  offs_ff;

   // Bank tracking.
   logic [BANK_W-1:0] cur_bank_ff;
   logic              bank_ok_ff;

   // Result stage.
   logic              out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic [7:0]        out_data_ff, out_data_in;
   logic [7:0]        out_mask_ff, out_mask_in;
   logic [1:0]        out_plane_ff, out_plane_in;
   logic              out_planar_ff, out_planar_in;
   logic              out_sw_ff, out_sw_in;
   logic [GRAN_W-1:0] out_gran_ff, out_gran_in;
   logic              out_win_ff, out_win_in;
   logic              out_last_ff;

   logic                bytewise;
   logic [ADDR_W-1:0]   offset;
   logic [ADDR_W-1:0]   bank_full;
   logic [BANK_W-1:0]   bank;
   logic [BANK_W+GPB_W-1:0] gran_prod;
   logic                new_bank;
   logic [7:0]          pix_mask1;
   logic [7:0]          pix_mask2;
   logic [COLOR_W-1:0]  c_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ROW_W'(640);
         fmt_ff       <= FMT_8BPP;
         banked_ff    <= 1'b0;
         gpb_ff       <= GPB_W'(1);
         win_sel_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROW_BYTES:  row_bytes_ff <= csr_data;
            CSR_PIXEL_FMT:  fmt_ff       <= csr_data[2:0];
            CSR_BANKED:     banked_ff    <= csr_data[0];
            CSR_GRANULES:   gpb_ff       <= csr_data[GPB_W-1:0];
            CSR_WINDOW_SEL: win_sel_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (fmt_ff)
         FMT_1BPP, FMT_PLANAR: xoff_in = ROW_W'(x_ff >> 3);
         FMT_2BPP:             xoff_in = ROW_W'(x_ff >> 2);
         FMT_8BPP:             xoff_in = ROW_W'(x_ff);
         FMT_16BPP:            xoff_in = {1'b0, x_ff, 1'b0};
         FMT_24BPP:            xoff_in = ROW_W'(x_ff) + {1'b0, x_ff, 1'b0};
         FMT_32BPP:            xoff_in = {x_ff, 2'b00};
         default:              xoff_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_pixel_x;
         y_ff <= req_pixel_y;
         c_ff <= req_color;
      end
      if (cmd.mult) begin
         prod_ff <= row_bytes_ff * y_ff;
         xoff_ff <= xoff_in;
      end
      if (cmd.sum) begin
         offs_ff <= prod_ff + ADDR_W'(xoff_ff);
      end
   end

   always_comb begin
      sts.out_free = !out_valid_ff || !rsp_stall;
      case (fmt_ff)
         FMT_1BPP, FMT_2BPP:   sts.nres = 3'd1;
         FMT_PLANAR:           sts.nres = 3'd4;
         FMT_8BPP:             sts.nres = 3'd1;
         FMT_16BPP:            sts.nres = 3'd2;
         FMT_24BPP:            sts.nres = 3'd3;
         FMT_32BPP:            sts.nres = 3'd4;
         default:              sts.nres = 3'd0;
      endcase
   end

   assign bytewise  = fmt_ff inside {FMT_8BPP, FMT_16BPP, FMT_24BPP, FMT_32BPP};
   assign offset    = bytewise ? offs_ff + ADDR_W'(cmd.index) : offs_ff;
   assign bank_full = offset >> WINDOW_BITS;
   assign bank      = bank_full[BANK_W-1:0];
   assign gran_prod = bank * gpb_ff;
   assign new_bank  = banked_ff && bytewise && (!bank_ok_ff || bank != cur_bank_ff);
   assign pix_mask1 = 8'h80 >> x_ff[2:0];
   assign pix_mask2 = 8'hC0 >> {x_ff[1:0], 1'b0};
   assign c_shift   = c_ff >> {cmd.index, 3'b000};

   always_comb begin
      out_addr_in   = (banked_ff && bytewise) ? (offset & WIN_MASK) : offset;
      out_data_in   = c_shift[7:0];
      out_mask_in   = 8'hFF;
      out_plane_in  = 2'd0;
      out_planar_in = 1'b0;
      out_sw_in     = new_bank;
      out_gran_in   = new_bank ? gran_prod[GRAN_W-1:0] : '0;
      out_win_in    = new_bank & win_sel_ff;
      case (fmt_ff)
         FMT_1BPP: begin
            out_data_in = {8{c_ff[0]}};
            out_mask_in = pix_mask1;
         end
         FMT_2BPP: begin
            out_data_in = {4{c_ff[1:0]}};
            out_mask_in = pix_mask2;
         end
         FMT_PLANAR: begin
            out_data_in   = {8{c_ff[cmd.index]}};
            out_mask_in   = pix_mask1;
            out_plane_in  = cmd.index;
            out_planar_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         cur_bank_ff  <= '1;
         bank_ok_ff   <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.emit && new_bank) begin
            cur_bank_ff <= bank;
            bank_ok_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_addr_ff   <= out_addr_in;
         out_data_ff   <= out_data_in;
         out_mask_ff   <= out_mask_in;
         out_plane_ff  <= out_plane_in;
         out_planar_ff <= out_planar_in;
         out_sw_ff     <= out_sw_in;
         out_gran_ff   <= out_gran_in;
         out_win_ff    <= out_win_in;
         out_last_ff   <= cmd.last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_address = out_addr_ff;
   assign rsp_byte_data    = out_data_ff;
   assign rsp_bit_mask     = out_mask_ff;
   assign rsp_plane        = out_plane_ff;
   assign rsp_planar       = out_planar_ff;
   assign rsp_bank_switch  = out_sw_ff;
   assign rsp_bank_granule = out_gran_ff;
   assign rsp_bank_window  = out_win_ff;
   assign rsp_last         = out_last_ff;

endmodule
`default_nettype wire

@@ rtl/framebuffer_pixel_write_generator.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// framebuffer_pixel_write_generator
// Turns one pixel (x, y, colour) into the masked byte writes that plot it.
// ---------------------------------------------------------------------------
// A taken pixel passes the registered row multiply and then the offset add;
// its 1 to 4 byte writes follow, one a cycle while the output register is free.
// The next pixel is taken once the last write sits in the output register.
// Synchronous reset restores the register defaults and forgets the current bank.
module framebuffer_pixel_write_generator
   import fpwg_pkg::*;
#(
   parameter int WINDOW_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [COORD_W-1:0]   req_pixel_x,
   input  wire logic [COORD_W-1:0]   req_pixel_y,
   input  wire logic [COLOR_W-1:0]   req_color,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ADDR_W-1:0]         rsp_byte_address,
   output logic [7:0]                rsp_byte_data,
   output logic [7:0]                rsp_bit_mask,
   output logic [1:0]                rsp_plane,
   output logic                      rsp_planar,
   output logic                      rsp_bank_switch,
   output logic [GRAN_W-1:0]         rsp_bank_granule,
   output logic                      rsp_bank_window,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   fpwg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fpwg_dp #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_color        (req_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_address (rsp_byte_address),
      .rsp_byte_data    (rsp_byte_data),
      .rsp_bit_mask     (rsp_bit_mask),
      .rsp_plane        (rsp_plane),
      .rsp_planar       (rsp_planar),
      .rsp_bank_switch  (rsp_bank_switch),
      .rsp_bank_granule (rsp_bank_granule),
      .rsp_bank_window  (rsp_bank_window),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   // A pixel that produces writes holds off the next one.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && sts.nres != 3'd0) |=> req_stall)
      else $error("pixel taken while the previous one is still in progress");

   // Planar writes select one pixel bit and never switch banks.
   a_planar_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_planar) |-> ($onehot(rsp_bit_mask) && !rsp_bank_switch))
      else $error("planar write with bad mask or bank switch");

   // Without a bank switch the granule and window fields stay clear.
   a_no_switch_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bank_switch) |-> (rsp_bank_granule == '0 && !rsp_bank_window))
      else $error("bank fields set without a bank switch");
`endif

endmodule
`default_nettype wire
